[design/bbs_pkg.sv]
// shared types and constants for the band select rgb scaler
// no dependencies
package bbs_pkg;

  localparam int CMP_W      = 14;
  localparam int COL_W      = 11;
  localparam int LINE_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int PROD_W     = 34;

  localparam logic [17:0]         SCALE_NUM  = 18'd262140;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_LINE = 3'd0,
    REG_BAND_COUNT       = 3'd1,
    REG_RED_BAND         = 3'd2,
    REG_GREEN_BAND       = 3'd3,
    REG_BLUE_BAND        = 3'd4,
    REG_SAMPLE_BITS      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] samples_per_line;
    logic [10:0] band_count;
    logic [9:0]  red_band;
    logic [9:0]  green_band;
    logic [9:0]  blue_band;
    logic [5:0]  sample_bits;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
    logic [COL_W-1:0]    column;
    logic [LINE_W-1:0]   line_number;
    logic                line_end;
  } q_entry_t;

endpackage

[design/bil_band_select_rgb_scaler.sv]
// channel  | ports                               | word
// in       | in_tvalid, in_tready, in_tdata      | one 16-bit sample, band-interleaved-by-line
// out      | out_tvalid, out_tready, out_tdata,  | one bgra pixel with column and line,
//          | out_tlast                           | tlast on the last column of a line
// cfg      | cfg_we, cfg_index, cfg_wdata        | one register write
//
// one sample per cycle while in_tready is high; a pixel leaves through the line store read
// stage, the queue and the scaler output register after its sample is taken
// rst_n is synchronous: counters clear and configuration registers return to their defaults
// the 4-entry queue lets the front keep taking samples while out_tready is low;
// in_tready drops once the queued pixels plus the one in the store read stage reach 4
// depends on bbs_pkg, bbs_front, bbs_queue, bbs_back
module bil_band_select_rgb_scaler import bbs_pkg::*; #(
  parameter int MAX_SAMPLES = 2048,
  parameter int MAX_BANDS   = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [95:0]           out_tdata,  // blue, green, red, alpha, column, line_number
  output logic                  out_tlast
);

  cfg_t              cfg_r;
  logic              accept;
  logic              push, pop, head_valid;
  q_entry_t          push_entry, head, out_pix;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   fill;
  logic [SAMPLE_W-1:0] out_alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_line <= 12'd1024;
      cfg_r.band_count       <= 11'd300;
      cfg_r.red_band         <= 10'd279;
      cfg_r.green_band       <= 10'd169;
      cfg_r.blue_band        <= 10'd69;
      cfg_r.sample_bits      <= 6'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_LINE: cfg_r.samples_per_line <= cfg_wdata;
        REG_BAND_COUNT:       cfg_r.band_count       <= cfg_wdata[10:0];
        REG_RED_BAND:         cfg_r.red_band         <= cfg_wdata[9:0];
        REG_GREEN_BAND:       cfg_r.green_band       <= cfg_wdata[9:0];
        REG_BLUE_BAND:        cfg_r.blue_band        <= cfg_wdata[9:0];
        REG_SAMPLE_BITS:      cfg_r.sample_bits      <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign fill      = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(push);
  assign in_tready = (fill < (QCNT_W + 1)'(QDEPTH));
  assign accept    = in_tvalid && in_tready;

  bbs_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_BANDS  (MAX_BANDS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .accept(accept),
    .sample(in_tdata),
    .push  (push),
    .entry (push_entry)
  );

  bbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head),
    .count     (q_count)
  );

  bbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_bits(cfg_r.sample_bits),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_pix    (out_pix),
    .out_alpha  (out_alpha)
  );

  assign out_tdata = {5'b0, out_pix.line_number, out_pix.column, out_alpha,
                      out_pix.red, out_pix.green, out_pix.blue};
  assign out_tlast = out_pix.line_end;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (QCNT_W + 1)'(q_count) <= (QCNT_W + 1)'(QDEPTH))
    else $error("pixel queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("store read pushed into a full queue");

  a_alpha_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[63:48] == 16'h0) ==
                    (out_tdata[47:0] == 48'h0)))
    else $error("alpha disagrees with colours");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("scaler took from an empty queue");
`endif

endmodule

[design/bbs_front.sv]
// front end: column, band and line counters, colour line stores, pixel issue
// depends on bbs_pkg
module bbs_front import bbs_pkg::*; #(
  parameter int MAX_SAMPLES = 2048,
  parameter int MAX_BANDS   = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                push,
  output q_entry_t            entry
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  logic [AW-1:0]     col_r, col_nxt;
  logic [BW-1:0]     band_r, band_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  logic [SAMPLE_W-1:0] red_mem   [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] green_mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] blue_mem  [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] red_rd_r, green_rd_r, blue_rd_r;

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_red_sel_r, s1_green_sel_r, s1_blue_sel_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [LINE_W-1:0]   s1_line_r;
  logic                s1_last_r;

  logic [CMP_W-1:0] spl_w, cols, col_w, col_eff_w;
  logic [CMP_W-1:0] bc_w, bands, band_w, band_eff_w;
  logic [AW-1:0]    col_eff;
  logic [9:0]       top_band;
  logic             last_col, band_wrap, emit;
  logic             red_hit, green_hit, blue_hit;

  always_comb begin
    spl_w = CMP_W'(cfg.samples_per_line);
    if (spl_w == '0) begin
      cols = CMP_W'(1);
    end else if (spl_w > CMP_W'(MAX_SAMPLES)) begin
      cols = CMP_W'(MAX_SAMPLES);
    end else begin
      cols = spl_w;
    end
    bc_w = CMP_W'(cfg.band_count);
    if (bc_w == '0) begin
      bands = CMP_W'(1);
    end else if (bc_w > CMP_W'(MAX_BANDS)) begin
      bands = CMP_W'(MAX_BANDS);
    end else begin
      bands = bc_w;
    end

    col_w      = CMP_W'(col_r);
    col_eff_w  = (col_w >= cols) ? '0 : col_w;
    col_eff    = col_eff_w[AW-1:0];
    band_w     = CMP_W'(band_r);
    band_eff_w = (band_w >= bands) ? '0 : band_w;

    last_col  = (col_eff_w == cols - CMP_W'(1));
    band_wrap = ((band_eff_w + CMP_W'(1)) >= bands);

    red_hit   = (band_eff_w == CMP_W'(cfg.red_band));
    green_hit = (band_eff_w == CMP_W'(cfg.green_band));
    blue_hit  = (band_eff_w == CMP_W'(cfg.blue_band));

    top_band = cfg.red_band;
    if (cfg.green_band > top_band) top_band = cfg.green_band;
    if (cfg.blue_band > top_band) top_band = cfg.blue_band;
    emit = (CMP_W'(top_band) < bands) && (band_eff_w == CMP_W'(top_band));

    col_nxt  = AW'(col_eff_w + CMP_W'(1));
    band_nxt = BW'(band_eff_w);
    line_nxt = line_r;
    if (last_col) begin
      col_nxt = '0;
      if (band_wrap) begin
        band_nxt = '0;
        line_nxt = line_r + LINE_W'(1);
      end else begin
        band_nxt = BW'(band_eff_w + CMP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      band_r     <= '0;
      line_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && emit;
      if (accept) begin
        col_r  <= col_nxt;
        band_r <= band_nxt;
        line_r <= line_nxt;
      end
    end
  end

  // line stores, read before write
  always_ff @(posedge clk) begin
    if (accept) begin
      red_rd_r   <= red_mem[col_eff];
      green_rd_r <= green_mem[col_eff];
      blue_rd_r  <= blue_mem[col_eff];
      if (red_hit) red_mem[col_eff] <= sample;
      if (green_hit) green_mem[col_eff] <= sample;
      if (blue_hit) blue_mem[col_eff] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r    <= sample;
      s1_red_sel_r   <= red_hit;
      s1_green_sel_r <= green_hit;
      s1_blue_sel_r  <= blue_hit;
      s1_col_r       <= col_eff_w[COL_W-1:0];
      s1_line_r      <= line_r;
      s1_last_r      <= last_col;
    end
  end

  // the top band's sample bypasses its own store
  always_comb begin
    push              = s1_valid_r;
    entry.red         = s1_red_sel_r ? s1_sample_r : red_rd_r;
    entry.green       = s1_green_sel_r ? s1_sample_r : green_rd_r;
    entry.blue        = s1_blue_sel_r ? s1_sample_r : blue_rd_r;
    entry.column      = s1_col_r;
    entry.line_number = s1_line_r;
    entry.line_end    = s1_last_r;
  end

endmodule

[design/bbs_queue.sv]
// short pixel queue between front end and scaler
// depends on bbs_pkg
module bbs_queue import bbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  q_entry_t          push_entry,
  input  logic              pop,
  output logic              head_valid,
  output q_entry_t          head,
  output logic [QCNT_W-1:0] count
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_entry;
  end

  assign head       = slots[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

[design/bbs_back.sv]
// back end: colour scaling, saturation, alpha and output register
// depends on bbs_pkg
module bbs_back import bbs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [5:0]      sample_bits,
  input  logic            head_valid,
  input  q_entry_t        head,
  output logic            pop,
  input  logic            out_ready,
  output logic            out_valid,
  output q_entry_t        out_pix,
  output logic [SAMPLE_W-1:0] out_alpha
);

  function automatic logic [SAMPLE_W-1:0] scale(input logic [SAMPLE_W-1:0] v,
                                                input logic [5:0] sb);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] s;
    p = PROD_W'(v) * PROD_W'(SCALE_NUM);
    s = p >> sb;
    return (s > PROD_W'(FULL_SCALE)) ? FULL_SCALE : s[SAMPLE_W-1:0];
  endfunction

  logic                out_valid_r;
  q_entry_t            pix_r, pix_nxt;
  logic [SAMPLE_W-1:0] alpha_r, alpha_nxt;

  always_comb begin
    pix_nxt       = head;
    pix_nxt.blue  = scale(head.blue, sample_bits);
    pix_nxt.green = scale(head.green, sample_bits);
    pix_nxt.red   = scale(head.red, sample_bits);
    alpha_nxt     = (pix_nxt.blue == '0 && pix_nxt.green == '0 && pix_nxt.red == '0) ?
                    '0 : FULL_SCALE;
    pop           = head_valid && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_r   <= pix_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = pix_r;
  assign out_alpha = alpha_r;

endmodule
